// File: rtl/bet_pkg.sv
// shared types and constants of the button edge tracker
// no dependencies
package bet_pkg;

   localparam int NUM_BUTTONS = 16;
   localparam int BTN_W = $clog2(NUM_BUTTONS);
   localparam int KEY_ENTRIES = 16;
   localparam int KEY_BITS = 9;
   localparam int KEY_SEARCH = (KEY_ENTRIES < NUM_BUTTONS) ? KEY_ENTRIES : NUM_BUTTONS;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_BUTTON = 2'd1;
   localparam logic [1:0] REQ_KEY    = 2'd2;

   localparam logic [2:0] CSR_OWN_DEVICE_ID = 3'd0;
   localparam logic [2:0] CSR_REPRESS_GAP   = 3'd1;
   localparam logic [2:0] CSR_KEYMAP_A      = 3'd2;
   localparam logic [2:0] CSR_KEYMAP_B      = 3'd3;
   localparam logic [2:0] CSR_KEYMAP_C      = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] device_id;
      logic [7:0]  button_index;
      logic [8:0]  key_code;
      logic        action;
      logic [31:0] event_time;
   } bet_request_type;

   typedef struct packed {
      logic [15:0] pressed_mask;
      logic [15:0] held_mask;
      logic [15:0] released_mask;
      logic [15:0] repressed_mask;
      logic        event_taken;
   } bet_response_type;

   typedef struct packed {
      logic [15:0] own_device_id;
      logic [31:0] repress_gap;
      logic [62:0] keymap_a;
      logic [62:0] keymap_b;
      logic [17:0] keymap_c;
   } bet_cfg_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_WRITE
   } bet_kind_type;

   typedef struct packed {
      bet_kind_type     kind;
      logic [BTN_W-1:0] button;
      logic             action;
      logic [31:0]      event_time;
   } bet_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bet_q_status_type;

endpackage

// File: rtl/bet_front.sv
// front end: takes requests and classifies them into row commands
// depends on bet_pkg
module bet_front import bet_pkg::*; (
   input  bet_cfg_type      cfg,
   input  logic             req_push,
   output logic             req_full,
   input  bet_request_type  req_data,
   input  bet_q_status_type q_status,
   output logic             q_push,
   output bet_cmd_type      q_cmd
);

   logic [KEY_BITS-1:0] key_entry [KEY_ENTRIES];
   logic                key_hit;
   logic [BTN_W-1:0]    key_button;
   logic                button_ok;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         key_entry[i]      = cfg.keymap_a[i*KEY_BITS +: KEY_BITS];
         key_entry[i + 7]  = cfg.keymap_b[i*KEY_BITS +: KEY_BITS];
      end
      key_entry[14] = cfg.keymap_c[0 +: KEY_BITS];
      key_entry[15] = cfg.keymap_c[KEY_BITS +: KEY_BITS];
   end

   // lowest matching entry wins
   always_comb begin
      key_hit    = 1'b0;
      key_button = '0;
      for (int i = KEY_SEARCH - 1; i >= 0; i--) begin
         if (key_entry[i] == req_data.key_code) begin
            key_hit    = 1'b1;
            key_button = BTN_W'(i);
         end
      end
   end

   assign button_ok = (req_data.device_id == cfg.own_device_id)
                      && (req_data.button_index < 8'(NUM_BUTTONS));

   always_comb begin
      q_cmd.kind       = CMD_NONE;
      q_cmd.button     = req_data.button_index[BTN_W-1:0];
      q_cmd.action     = req_data.action;
      q_cmd.event_time = req_data.event_time;
      unique case (req_data.req_type)
         REQ_TICK: begin
            q_cmd.kind = CMD_TICK;
         end
         REQ_BUTTON: begin
            if (button_ok) q_cmd.kind = CMD_WRITE;
         end
         REQ_KEY: begin
            if (key_hit) begin
               q_cmd.kind   = CMD_WRITE;
               q_cmd.button = key_button;
            end
         end
         default: begin
            q_cmd.kind = CMD_NONE;
         end
      endcase
   end

   assign req_full = q_status.full;
   assign q_push   = req_push && !q_status.full;

endmodule

// File: rtl/bet_cmd_queue.sv
// two-entry command queue between front and back end
// depends on bet_pkg
module bet_cmd_queue import bet_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bet_cmd_type      push_cmd,
   input  logic             pop,
   output bet_cmd_type      head_cmd,
   output bet_q_status_type status
);

   bet_cmd_type mem [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign status.full  = (count_ff == 2'(QUEUE_DEPTH));
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_cmd;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("command queue count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("command queue lost a push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (status.empty || status.full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree with count");

endmodule

// File: rtl/bet_back.sv
// back end: applies commands to the frame rows and press history,
// builds the edge masks and queues the results; depends on bet_pkg
module bet_back import bet_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bet_cfg_type      cfg,
   input  bet_q_status_type q_status,
   input  bet_cmd_type      q_cmd,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bet_response_type rsp_data
);

   logic [NUM_BUTTONS-1:0] current_row_ff, current_row_in;
   logic [NUM_BUTTONS-1:0] previous_row_ff, previous_row_in;
   logic [NUM_BUTTONS-1:0] older_row_ff, older_row_in;
   logic [31:0]            last_time_ff [NUM_BUTTONS];
   logic [31:0]            last_time_in [NUM_BUTTONS];
   logic [31:0]            earlier_time_ff [NUM_BUTTONS];
   logic [31:0]            earlier_time_in [NUM_BUTTONS];

   bet_response_type out_mem [QUEUE_DEPTH];
   bet_response_type result;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             out_room, go, do_rsp_pop;
   logic [NUM_BUTTONS-1:0] pressed, repressed;

   assign do_rsp_pop = rsp_pop && (count_ff != 2'd0);
   assign out_room   = (count_ff != 2'(QUEUE_DEPTH)) || do_rsp_pop;
   assign go         = !q_status.empty && out_room;
   assign q_pop      = go;

   always_comb begin
      current_row_in  = current_row_ff;
      previous_row_in = previous_row_ff;
      older_row_in    = older_row_ff;
      last_time_in    = last_time_ff;
      earlier_time_in = earlier_time_ff;
      unique case (q_cmd.kind)
         CMD_TICK: begin
            older_row_in    = previous_row_ff;
            previous_row_in = current_row_ff;
            current_row_in  = '0;
         end
         CMD_WRITE: begin
            current_row_in[q_cmd.button] = q_cmd.action;
            if (q_cmd.action) begin
               earlier_time_in[q_cmd.button] = last_time_ff[q_cmd.button];
               last_time_in[q_cmd.button]    = q_cmd.event_time;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pressed = previous_row_in & ~older_row_in;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         repressed[i] = pressed[i]
                        && ((last_time_in[i] - earlier_time_in[i]) >= cfg.repress_gap);
      end
      result.pressed_mask   = 16'(pressed);
      result.held_mask      = 16'(previous_row_in);
      result.released_mask  = 16'(~previous_row_in & older_row_in);
      result.repressed_mask = 16'(repressed);
      result.event_taken    = (q_cmd.kind == CMD_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_row_ff  <= '0;
         previous_row_ff <= '0;
         older_row_ff    <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            last_time_ff[i]    <= '0;
            earlier_time_ff[i] <= '0;
         end
      end else if (go) begin
         current_row_ff  <= current_row_in;
         previous_row_ff <= previous_row_in;
         older_row_ff    <= older_row_in;
         last_time_ff    <= last_time_in;
         earlier_time_ff <= earlier_time_in;
      end
   end

   // result queue
   always_comb begin
      wr_ptr_in = go ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rsp_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(go) - 2'(do_rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) out_mem[wr_ptr_ff] <= result;
   end

   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = out_mem[rd_ptr_ff];

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (go && q_cmd.kind == CMD_TICK) |=> (current_row_ff == '0))
      else $error("frame tick did not clear current row");

   a_tick_shifts: assert property (@(posedge clock) disable iff (reset)
      (go && q_cmd.kind == CMD_TICK) |=> (previous_row_ff == $past(current_row_ff)))
      else $error("frame tick did not shift rows");

   a_release_keeps_time: assert property (@(posedge clock) disable iff (reset)
      (go && q_cmd.kind == CMD_WRITE && !q_cmd.action)
      |=> (last_time_ff[$past(q_cmd.button)] == $past(last_time_ff[q_cmd.button])))
      else $error("release changed press history");

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

// File: rtl/button_edge_tracker.sv
// top level of the button edge tracker: configuration registers,
// front end, command queue and back end; depends on bet_pkg and the bet_ modules
//
// Tracks 16 buttons over three frame rows (current, previous, older). A
// frame tick shifts the rows and clears the current row; a button event
// from the configured device, or a key event found in the key table, writes
// one bit of the current row, and a press also keeps the last two press
// times of that button. Every transaction on the request queue gives one
// response transaction with pressed, held, released and re-pressed masks
// taken after the request is applied. Requests are taken one per cycle
// while req_full is low: the front end classifies a request in the cycle
// it is pushed, a two-entry command queue holds it, and the back end
// applies it and builds its masks combinationally, writing them to a
// two-entry response queue. Configuration writes are taken every cycle
// (csr_ready stays high) and should be done while no request is in
// flight; writes to an index past the last register are dropped.
module button_edge_tracker import bet_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bet_request_type  req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bet_response_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);

   bet_cfg_type      cfg_ff, cfg_in;
   bet_q_status_type q_status;
   bet_cmd_type      push_cmd, head_cmd;
   logic             q_push, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OWN_DEVICE_ID: cfg_in.own_device_id = csr_data[15:0];
            CSR_REPRESS_GAP:   cfg_in.repress_gap   = csr_data[31:0];
            CSR_KEYMAP_A:      cfg_in.keymap_a      = csr_data[62:0];
            CSR_KEYMAP_B:      cfg_in.keymap_b      = csr_data[62:0];
            CSR_KEYMAP_C:      cfg_in.keymap_c      = csr_data[17:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bet_front u_front (
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   bet_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   bet_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
